### design/mtpdt_pkg.sv
// shared types and constants of the multisample pixel depth test
// no dependencies

package mtpdt_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 16;
    localparam int DEPTH_W    = 24;
    localparam int COLOR_W    = 24;
    localparam int CH_W       = 8;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int PIDX_W     = 16;
    localparam int COV_W      = 5;
    localparam int PT_W       = 18;
    localparam int CROSS_W    = 35;
    localparam int NUM_W      = 61;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 9'd256;

    localparam logic signed [DEPTH_W-1:0] FAR_DEPTH  = 24'sh7FFFFF;
    localparam logic signed [DEPTH_W-1:0] NEAR_DEPTH = 24'sh800000;

    localparam logic [3:0] SAMPLE_FIRST = 4'd2;
    localparam logic [3:0] SAMPLE_NONE  = 4'd0;
    localparam logic [COV_W-1:0] COV_FULL = 5'd16;

endpackage

### design/mtpdt_if.sv
// handshake channels: pixel items, result items, configuration writes
// depends on mtpdt_pkg

interface mtpdt_in_if;
    import mtpdt_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [PIX_W-1:0]            pixel_x;
    logic [PIX_W-1:0]            pixel_y;
    logic signed [COORD_W-1:0]   vertex_x0;
    logic signed [COORD_W-1:0]   vertex_y0;
    logic signed [DEPTH_W-1:0]   vertex_z0;
    logic signed [COORD_W-1:0]   vertex_x1;
    logic signed [COORD_W-1:0]   vertex_y1;
    logic signed [DEPTH_W-1:0]   vertex_z1;
    logic signed [COORD_W-1:0]   vertex_x2;
    logic signed [COORD_W-1:0]   vertex_y2;
    logic signed [DEPTH_W-1:0]   vertex_z2;
    logic [COLOR_W-1:0]          tri_color;

    modport source (output valid, pixel_x, pixel_y, vertex_x0, vertex_y0, vertex_z0,
                    vertex_x1, vertex_y1, vertex_z1, vertex_x2, vertex_y2, vertex_z2,
                    tri_color, input ready);
    modport sink (input valid, pixel_x, pixel_y, vertex_x0, vertex_y0, vertex_z0,
                  vertex_x1, vertex_y1, vertex_z1, vertex_x2, vertex_y2, vertex_z2,
                  tri_color, output ready);
endinterface

interface mtpdt_out_if;
    import mtpdt_pkg::*;
    logic              valid;
    logic              ready;
    logic              written;
    logic [PIDX_W-1:0] pixel_index;
    logic [COV_W-1:0]  coverage;
    logic [CH_W-1:0]   out_red;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_blue;

    modport source (output valid, written, pixel_index, coverage, out_red, out_green,
                    out_blue, input ready);
    modport sink (input valid, written, pixel_index, coverage, out_red, out_green,
                  out_blue, output ready);
endinterface

interface mtpdt_cfg_if;
    import mtpdt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, reg_index, data, input ready);
    modport sink (input valid, reg_index, data, output ready);
endinterface

### design/mtpdt_div.sv
// signed divider, restoring, one quotient bit per cycle, truncates toward zero
// depends on nothing but its parameters

module mtpdt_div #(
    parameter int NUM_W = 61,
    parameter int DEN_W = 35
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_d;
    logic [DEN_W-1:0] r_rem;
    logic             r_neg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        diff  = trial - {1'b0, r_d};
        fits  = trial >= {1'b0, r_d};
        n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_d   <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_rem <= '0;
            r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

### design/mtpdt_depth_mem.sv
// depth store: single-port write, registered read, cleared to farthest after reset
// depends on mtpdt_pkg

module mtpdt_depth_mem #(
    parameter int DEPTH = 65536
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]              i_rd_addr,
    output logic signed [mtpdt_pkg::DEPTH_W-1:0]  o_rd_data,
    input  logic                                  i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]              i_wr_addr,
    input  logic signed [mtpdt_pkg::DEPTH_W-1:0]  i_wr_data,
    output logic                                  o_busy
);
    import mtpdt_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [DEPTH_W-1:0] mem [DEPTH];
    logic [DEPTH_W-1:0] r_rd_data;
    logic               r_busy;
    logic [ADDR_W-1:0]  r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= FAR_DEPTH;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = $signed(r_rd_data);
    assign o_busy    = r_busy;

endmodule

### design/msaa_triangle_pixel_depth_test.sv
// top level: 4x4 multisample coverage, depth interpolation and depth-buffer test
// depends on mtpdt_pkg, mtpdt_if, mtpdt_div, mtpdt_depth_mem
//
// channels: i_in takes one pixel with a triangle per beat, o_out returns one
// result beat per pixel, i_cfg writes frame_width (index 0) and frame_height
// (index 1) and is always ready.
// one pixel is worked at a time. a shared cross-product unit runs first, then
// the coverage walk steps one sub-sample a cycle; a pixel that needs no depth
// test then goes to the output register. a depth test adds multiply-accumulate
// steps, a divider start, the serial divider (61 quotient bits, one a cycle,
// then its done strobe) and a depth-store read and compare.
// the next pixel is taken as soon as the sequencer is idle, while the last
// result may still wait in the output register; a stalled receiver only holds
// that register and stops the sequencer once its next result is ready.
// after reset the depth store is cleared to farthest, one entry a cycle
// (all MAX_WIDTH*MAX_HEIGHT entries, 65536 by default); no pixel is taken
// meanwhile. frame registers reset to 256.

module msaa_triangle_pixel_depth_test #(
    parameter int MAX_WIDTH  = mtpdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mtpdt_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtpdt_in_if.sink    i_in,
    mtpdt_out_if.source o_out,
    mtpdt_cfg_if.sink   i_cfg
);
    import mtpdt_pkg::*;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int MW_W       = $clog2(MAX_WIDTH + 1);
    localparam int MH_W       = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_W      = (MW_W > CFG_W) ? ((MH_W > MW_W) ? MH_W : MW_W)
                                               : ((MH_W > CFG_W) ? MH_W : CFG_W);
    localparam int IDX_W      = 2 * DIM_W;
    localparam int PROD_W     = 43;
    localparam int HI_SHIFT   = 18;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CROSS = 4'd1;
    localparam logic [3:0] S_COV   = 4'd2;
    localparam logic [3:0] S_IDX   = 4'd3;
    localparam logic [3:0] S_MAC   = 4'd4;
    localparam logic [3:0] S_DIVGO = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_PUT   = 4'd9;

    localparam logic [2:0] K_EDGE0 = 3'd0;
    localparam logic [2:0] K_EDGE1 = 3'd1;
    localparam logic [2:0] K_EDGE2 = 3'd2;
    localparam logic [2:0] K_AREA  = 3'd3;
    localparam logic [2:0] K_BARY0 = 3'd4;
    localparam logic [2:0] K_BARY1 = 3'd5;
    localparam logic [2:0] K_BARY2 = 3'd6;
    localparam logic [2:0] M_FIRST = 3'd0;
    localparam logic [2:0] M_LAST  = 3'd6;

    // sequencer and item registers
    logic [3:0]                r_state;
    logic [2:0]                r_k;
    logic [2:0]                r_m;
    logic                      r_hi;
    logic [3:0]                r_cnt;
    logic [PIX_W-1:0]          r_px;
    logic [PIX_W-1:0]          r_py;
    logic signed [COORD_W-1:0] r_vx [3];
    logic signed [COORD_W-1:0] r_vy [3];
    logic signed [DEPTH_W-1:0] r_vz [3];
    logic [COLOR_W-1:0]        r_color;
    logic signed [CROSS_W-1:0] r_cur [3];
    logic signed [CROSS_W-1:0] r_row [3];
    logic signed [CROSS_W-1:0] r_e [3];
    logic signed [CROSS_W-1:0] r_area;
    logic [COV_W-1:0]          r_cov;
    logic [IDX_W-1:0]          r_idx;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [NUM_W-1:0]   r_acc;
    logic signed [DEPTH_W-1:0] r_z;
    logic                      r_wr;
    logic [CFG_W-1:0]          r_fw;
    logic [CFG_W-1:0]          r_fh;

    logic                      r_ovalid;
    logic                      r_owritten;
    logic [PIDX_W-1:0]         r_oindex;
    logic [COV_W-1:0]          r_ocov;
    logic [CH_W-1:0]           r_ored;
    logic [CH_W-1:0]           r_ogreen;
    logic [CH_W-1:0]           r_oblue;

    // cross-product unit operands
    logic signed [PT_W-1:0]    vx18 [3];
    logic signed [PT_W-1:0]    vy18 [3];
    logic signed [PT_W-1:0]    sx18, sy18, cx18, cy18;
    logic signed [PT_W-1:0]    p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
    logic signed [PT_W-1:0]    ux, uy, vx, vy;
    logic signed [2*PT_W-1:0]  m_a, m_b;
    logic signed [2*PT_W:0]    cross_full;
    logic signed [CROSS_W-1:0] cross_v;

    logic signed [PT_W-1:0]    dx [3];
    logic signed [PT_W-1:0]    dy [3];
    logic                      in_tri;

    logic [DIM_W-1:0]          eff_w, eff_h, rowm;
    logic                      on_frame;

    logic [1:0]                mk;
    logic signed [18:0]        mac_op;
    logic signed [NUM_W-1:0]   prod_ext;

    logic                      div_done;
    logic signed [NUM_W-1:0]   div_quot;
    logic signed [DEPTH_W-1:0] z_sat;

    logic                      mem_rd_en;
    logic                      mem_wr_en;
    logic                      mem_busy;
    logic signed [DEPTH_W-1:0] mem_rd_data;
    logic                      take_z;

    logic [12:0]               red_full, green_full, blue_full;
    logic                      out_free;
    logic                      in_fire;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vx18[k] = PT_W'(r_vx[k]);
            vy18[k] = PT_W'(r_vy[k]);
        end
        sx18 = $signed({6'd0, r_px, SAMPLE_FIRST});
        sy18 = $signed({6'd0, r_py, SAMPLE_FIRST});
        cx18 = $signed({6'd0, r_px, SAMPLE_NONE});
        cy18 = $signed({6'd0, r_py, SAMPLE_NONE});
    end

    // edge k runs from vertex k to vertex k+1
    always_comb begin
        dx[0] = vx18[0] - vx18[1];
        dy[0] = vy18[0] - vy18[1];
        dx[1] = vx18[1] - vx18[2];
        dy[1] = vy18[1] - vy18[2];
        dx[2] = vx18[2] - vx18[0];
        dy[2] = vy18[2] - vy18[0];
    end

    // cross(p1 - p2, p3 - p4)
    always_comb begin
        p1x = vx18[0]; p1y = vy18[0]; p2x = vx18[1]; p2y = vy18[1];
        p3x = sx18;    p3y = sy18;    p4x = vx18[1]; p4y = vy18[1];
        unique case (r_k)
            K_EDGE0: begin
                p1x = vx18[0]; p1y = vy18[0]; p2x = vx18[1]; p2y = vy18[1];
                p3x = sx18;    p3y = sy18;    p4x = vx18[1]; p4y = vy18[1];
            end
            K_EDGE1: begin
                p1x = vx18[1]; p1y = vy18[1]; p2x = vx18[2]; p2y = vy18[2];
                p3x = sx18;    p3y = sy18;    p4x = vx18[2]; p4y = vy18[2];
            end
            K_EDGE2: begin
                p1x = vx18[2]; p1y = vy18[2]; p2x = vx18[0]; p2y = vy18[0];
                p3x = sx18;    p3y = sy18;    p4x = vx18[0]; p4y = vy18[0];
            end
            K_AREA: begin
                p1x = vx18[1]; p1y = vy18[1]; p2x = vx18[0]; p2y = vy18[0];
                p3x = vx18[2]; p3y = vy18[2]; p4x = vx18[0]; p4y = vy18[0];
            end
            K_BARY0: begin
                p1x = vx18[1]; p1y = vy18[1]; p2x = cx18;    p2y = cy18;
                p3x = vx18[2]; p3y = vy18[2]; p4x = cx18;    p4y = cy18;
            end
            K_BARY1: begin
                p1x = vx18[2]; p1y = vy18[2]; p2x = cx18;    p2y = cy18;
                p3x = vx18[0]; p3y = vy18[0]; p4x = cx18;    p4y = cy18;
            end
            K_BARY2: begin
                p1x = vx18[0]; p1y = vy18[0]; p2x = cx18;    p2y = cy18;
                p3x = vx18[1]; p3y = vy18[1]; p4x = cx18;    p4y = cy18;
            end
            default: begin
                p1x = vx18[0]; p1y = vy18[0]; p2x = vx18[1]; p2y = vy18[1];
                p3x = sx18;    p3y = sy18;    p4x = vx18[1]; p4y = vy18[1];
            end
        endcase
        ux         = p1x - p2x;
        uy         = p1y - p2y;
        vx         = p3x - p4x;
        vy         = p3y - p4y;
        m_a        = ux * vy;
        m_b        = uy * vx;
        cross_full = (2*PT_W+1)'(m_a) - (2*PT_W+1)'(m_b);
        cross_v    = cross_full[CROSS_W-1:0];
    end

    assign in_tri = (r_cur[0][CROSS_W-1] == r_cur[1][CROSS_W-1]) &&
                    (r_cur[1][CROSS_W-1] == r_cur[2][CROSS_W-1]);

    always_comb begin
        eff_w    = (DIM_W'(r_fw) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(r_fw);
        eff_h    = (DIM_W'(r_fh) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(r_fh);
        rowm     = eff_h - DIM_W'(1) - DIM_W'(r_py);
        on_frame = (DIM_W'(r_px) < eff_w) && (DIM_W'(r_py) < eff_h);
    end

    // depth numerator: each bary value split into a signed high and unsigned low part
    always_comb begin
        mk       = (r_m[2:1] == 2'd3) ? 2'd2 : r_m[2:1];
        mac_op   = r_m[0] ? 19'($signed(r_e[mk][CROSS_W-1:HI_SHIFT]))
                          : $signed({1'b0, r_e[mk][HI_SHIFT-1:0]});
        prod_ext = r_hi ? (NUM_W'(r_prod) <<< HI_SHIFT) : NUM_W'(r_prod);
    end

    always_comb begin
        if (div_quot > NUM_W'(FAR_DEPTH)) begin
            z_sat = FAR_DEPTH;
        end else if (div_quot < NUM_W'(NEAR_DEPTH)) begin
            z_sat = NEAR_DEPTH;
        end else begin
            z_sat = div_quot[DEPTH_W-1:0];
        end
    end

    assign take_z     = r_z < mem_rd_data;
    assign mem_rd_en  = r_state == S_RD;
    assign mem_wr_en  = (r_state == S_CMP) && take_z;
    assign red_full   = 13'(r_color[23:16]) * 13'(r_cov);
    assign green_full = 13'(r_color[15:8]) * 13'(r_cov);
    assign blue_full  = 13'(r_color[7:0]) * 13'(r_cov);
    assign out_free   = !r_ovalid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == S_IDLE) && !mem_busy;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= CFG_DIM_RESET;
            r_fh <= CFG_DIM_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == REG_FRAME_WIDTH) begin
                r_fw <= i_cfg.data;
            end else if (i_cfg.reg_index == REG_FRAME_HEIGHT) begin
                r_fh <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready && !((r_state == S_PUT) && out_free)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    if (r_k == K_BARY2) begin
                        r_state <= S_COV;
                    end
                end
                S_COV: begin
                    if (r_cnt == 4'd15) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_state <= ((r_cov != '0) && on_frame) ? S_MAC : S_PUT;
                end
                S_MAC: begin
                    if (r_m == M_LAST) begin
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= S_CMP;
                S_CMP: r_state <= S_PUT;
                S_PUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_px      <= i_in.pixel_x;
                r_py      <= i_in.pixel_y;
                r_vx[0]   <= i_in.vertex_x0;
                r_vy[0]   <= i_in.vertex_y0;
                r_vz[0]   <= i_in.vertex_z0;
                r_vx[1]   <= i_in.vertex_x1;
                r_vy[1]   <= i_in.vertex_y1;
                r_vz[1]   <= i_in.vertex_z1;
                r_vx[2]   <= i_in.vertex_x2;
                r_vy[2]   <= i_in.vertex_y2;
                r_vz[2]   <= i_in.vertex_z2;
                r_color   <= i_in.tri_color;
                r_k       <= K_EDGE0;
            end
            S_CROSS: begin
                r_k <= r_k + 1'b1;
                unique case (r_k)
                    K_EDGE0: begin
                        r_cur[0] <= cross_v;
                        r_row[0] <= cross_v;
                    end
                    K_EDGE1: begin
                        r_cur[1] <= cross_v;
                        r_row[1] <= cross_v;
                    end
                    K_EDGE2: begin
                        r_cur[2] <= cross_v;
                        r_row[2] <= cross_v;
                    end
                    K_AREA:  r_area <= cross_v;
                    K_BARY0: r_e[0] <= cross_v;
                    K_BARY1: r_e[1] <= cross_v;
                    K_BARY2: r_e[2] <= cross_v;
                    default: r_area <= cross_v;
                endcase
                r_cnt <= '0;
                r_cov <= '0;
            end
            S_COV: begin
                r_cnt <= r_cnt + 1'b1;
                if (in_tri && (r_area != '0)) begin
                    r_cov <= r_cov + 1'b1;
                end
                // x steps along a row, y steps at row end
                for (int k = 0; k < 3; k++) begin
                    if (r_cnt[1:0] == 2'd3) begin
                        r_row[k] <= r_row[k] + (CROSS_W'(dx[k]) <<< 2);
                        r_cur[k] <= r_row[k] + (CROSS_W'(dx[k]) <<< 2);
                    end else begin
                        r_cur[k] <= r_cur[k] - (CROSS_W'(dy[k]) <<< 2);
                    end
                end
            end
            S_IDX: begin
                r_idx <= IDX_W'(rowm) * IDX_W'(eff_w) + IDX_W'(r_px);
                r_wr  <= 1'b0;
                r_m   <= M_FIRST;
                r_acc <= '0;
            end
            S_MAC: begin
                r_m    <= r_m + 1'b1;
                r_hi   <= r_m[0];
                r_prod <= mac_op * r_vz[mk];
                if (r_m != M_FIRST) begin
                    r_acc <= r_acc + prod_ext;
                end
            end
            S_DIV: begin
                r_z <= z_sat;
            end
            S_CMP: begin
                r_wr <= take_z;
            end
            S_PUT: begin
                if (out_free) begin
                    r_owritten <= r_wr;
                    r_ocov     <= r_cov;
                    r_oindex   <= r_wr ? r_idx[PIDX_W-1:0] : '0;
                    r_ored     <= r_wr ? red_full[11:4] : '0;
                    r_ogreen   <= r_wr ? green_full[11:4] : '0;
                    r_oblue    <= r_wr ? blue_full[11:4] : '0;
                end
            end
            default: begin
                r_hi <= 1'b0;
            end
        endcase
    end

    mtpdt_div #(
        .NUM_W (NUM_W),
        .DEN_W (CROSS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_acc),
        .i_den   (r_area),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    mtpdt_depth_mem #(
        .DEPTH (STORE_SIZE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_idx[ADDR_W-1:0]),
        .i_wr_data (r_z),
        .o_busy    (mem_busy)
    );

    assign o_out.valid       = r_ovalid;
    assign o_out.written     = r_owritten;
    assign o_out.pixel_index = r_oindex;
    assign o_out.coverage    = r_ocov;
    assign o_out.out_red     = r_ored;
    assign o_out.out_green   = r_ogreen;
    assign o_out.out_blue    = r_oblue;

endmodule

### design/mtpdt_checker.sv
// port-level checks of the pixel depth test, bound to the top level
// depends on mtpdt_pkg and msaa_triangle_pixel_depth_test

module mtpdt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic                               i_written,
    input logic [mtpdt_pkg::PIDX_W-1:0]       i_pixel_index,
    input logic [mtpdt_pkg::COV_W-1:0]        i_coverage,
    input logic [mtpdt_pkg::CH_W-1:0]         i_red,
    input logic [mtpdt_pkg::CH_W-1:0]         i_green,
    input logic [mtpdt_pkg::CH_W-1:0]         i_blue
);
    import mtpdt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_written |->
            i_pixel_index == '0 && i_red == '0 && i_green == '0 && i_blue == '0)
        else $error("non-write beat carries address or color");

    a_write_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_written |-> i_coverage != '0 && i_coverage <= COV_FULL)
        else $error("write beat with bad coverage");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second pixel taken while one is in work");

endmodule

bind msaa_triangle_pixel_depth_test mtpdt_checker u_mtpdt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_written     (o_out.written),
    .i_pixel_index (o_out.pixel_index),
    .i_coverage    (o_out.coverage),
    .i_red         (o_out.out_red),
    .i_green       (o_out.out_green),
    .i_blue        (o_out.out_blue)
);

### dv/msaa_triangle_pixel_depth_test_test.sv
// testbench for msaa_triangle_pixel_depth_test: directed and random pixels against a
// coverage/depth predictor held in a small scoreboard class
// depends on mtpdt_pkg, mtpdt_if and the design files
`timescale 1ns / 1ps

module msaa_triangle_pixel_depth_test_test;
    import mtpdt_pkg::*;

    typedef struct {
        logic [PIX_W-1:0]          pixel_x;
        logic [PIX_W-1:0]          pixel_y;
        logic signed [COORD_W-1:0] vx[3];
        logic signed [COORD_W-1:0] vy[3];
        logic signed [DEPTH_W-1:0] vz[3];
        logic [COLOR_W-1:0]        tri_color;
    } pixel_beat_t;

    typedef struct {
        logic              written;
        logic [PIDX_W-1:0] pixel_index;
        logic [COV_W-1:0]  coverage;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
    } write_beat_t;

    class pixel_write_board;
        int          z_store[DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
        int          frame_w;
        int          frame_h;
        write_beat_t expected_writes[$];
        int          mismatches;

        function new();
            foreach (z_store[i]) z_store[i] = FAR_DEPTH;
            frame_w = DEF_MAX_WIDTH;
            frame_h = DEF_MAX_HEIGHT;
            mismatches = 0;
        endfunction

        static function longint edge_val(longint px, longint py, longint bx, longint by,
                                         longint cx, longint cy);
            return px * (by - cy) + (cx - bx) * py + bx * cy - cx * by;
        endfunction

        static function longint cross_z(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
            return (ax - bx) * (py - by) - (ay - by) * (px - bx);
        endfunction

        function void note_pixel(pixel_beat_t b);
            write_beat_t r;
            longint x[3], y[3], z[3], cx, cy, area, e0, e1, e2, depth, sx, sy, c1, c2, c3;
            int cov, w, h, idx;
            for (int k = 0; k < 3; k++) begin
                x[k] = b.vx[k];
                y[k] = b.vy[k];
                z[k] = b.vz[k];
            end
            cx = 16 * longint'(b.pixel_x);
            cy = 16 * longint'(b.pixel_y);
            area = edge_val(x[0], y[0], x[1], y[1], x[2], y[2]);
            w = frame_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : frame_w;
            h = frame_h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : frame_h;
            cov = 0;
            r = '{default: '0};
            if (area != 0) begin
                for (int i = 0; i < 4; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        sx = cx + 2 + 4 * i;
                        sy = cy + 2 + 4 * j;
                        c1 = cross_z(x[0], y[0], x[1], y[1], sx, sy);
                        c2 = cross_z(x[1], y[1], x[2], y[2], sx, sy);
                        c3 = cross_z(x[2], y[2], x[0], y[0], sx, sy);
                        if ((c1 >= 0 && c2 >= 0 && c3 >= 0) || (c1 < 0 && c2 < 0 && c3 < 0))
                            cov++;
                    end
                end
            end
            if (cov > 0 && b.pixel_x < w && b.pixel_y < h) begin
                e0 = edge_val(cx, cy, x[1], y[1], x[2], y[2]);
                e1 = edge_val(cx, cy, x[2], y[2], x[0], y[0]);
                e2 = edge_val(cx, cy, x[0], y[0], x[1], y[1]);
                depth = (e0 * z[0] + e1 * z[1] + e2 * z[2]) / area;
                if (depth > FAR_DEPTH) depth = FAR_DEPTH;
                if (depth < NEAR_DEPTH) depth = NEAR_DEPTH;
                idx = (h - 1 - b.pixel_y) * w + b.pixel_x;
                if (depth < z_store[idx]) begin
                    z_store[idx] = int'(depth);
                    r.written = 1'b1;
                    r.pixel_index = idx[PIDX_W-1:0];
                    r.red   = 8'((32'(b.tri_color[23:16]) * cov) >> 4);
                    r.green = 8'((32'(b.tri_color[15:8]) * cov) >> 4);
                    r.blue  = 8'((32'(b.tri_color[7:0]) * cov) >> 4);
                end
            end
            r.coverage = cov[COV_W-1:0];
            expected_writes.push_back(r);
        endfunction

        function void check_result(write_beat_t got);
            write_beat_t e;
            if (expected_writes.size() == 0) begin
                $display("%0t unexpected result beat: written %0d index %0d cov %0d",
                         $time, got.written, got.pixel_index, got.coverage);
                mismatches++;
                return;
            end
            e = expected_writes.pop_front();
            if (got.written !== e.written) begin
                $display("%0t written exp %0d got %0d", $time, e.written, got.written);
                mismatches++;
            end
            if (got.pixel_index !== e.pixel_index) begin
                $display("%0t pixel_index exp %0d got %0d", $time, e.pixel_index,
                         got.pixel_index);
                mismatches++;
            end
            if (got.coverage !== e.coverage) begin
                $display("%0t coverage exp %0d got %0d", $time, e.coverage, got.coverage);
                mismatches++;
            end
            if (got.red !== e.red) begin
                $display("%0t out_red exp %0d got %0d", $time, e.red, got.red);
                mismatches++;
            end
            if (got.green !== e.green) begin
                $display("%0t out_green exp %0d got %0d", $time, e.green, got.green);
                mismatches++;
            end
            if (got.blue !== e.blue) begin
                $display("%0t out_blue exp %0d got %0d", $time, e.blue, got.blue);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    mtpdt_in_if  in_ch();
    mtpdt_out_if out_ch();
    mtpdt_cfg_if cfg_ch();

    pixel_write_board board = new();

    msaa_triangle_pixel_depth_test u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // beat monitors
    always @(posedge i_clk) begin
        pixel_beat_t b;
        write_beat_t r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            b.pixel_x = in_ch.pixel_x;
            b.pixel_y = in_ch.pixel_y;
            b.vx = '{in_ch.vertex_x0, in_ch.vertex_x1, in_ch.vertex_x2};
            b.vy = '{in_ch.vertex_y0, in_ch.vertex_y1, in_ch.vertex_y2};
            b.vz = '{in_ch.vertex_z0, in_ch.vertex_z1, in_ch.vertex_z2};
            b.tri_color = in_ch.tri_color;
            board.note_pixel(b);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.written = out_ch.written;
            r.pixel_index = out_ch.pixel_index;
            r.coverage = out_ch.coverage;
            r.red = out_ch.out_red;
            r.green = out_ch.out_green;
            r.blue = out_ch.out_blue;
            board.check_result(r);
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pixel(pixel_beat_t b);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pixel_x   <= b.pixel_x;
        in_ch.pixel_y   <= b.pixel_y;
        in_ch.vertex_x0 <= b.vx[0];
        in_ch.vertex_y0 <= b.vy[0];
        in_ch.vertex_z0 <= b.vz[0];
        in_ch.vertex_x1 <= b.vx[1];
        in_ch.vertex_y1 <= b.vy[1];
        in_ch.vertex_z1 <= b.vz[1];
        in_ch.vertex_x2 <= b.vx[2];
        in_ch.vertex_y2 <= b.vy[2];
        in_ch.vertex_z2 <= b.vz[2];
        in_ch.tri_color <= b.tri_color;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= REG_FRAME_WIDTH;
        cfg_ch.data      <= w[CFG_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.frame_w = w;
        cfg_ch.reg_index <= REG_FRAME_HEIGHT;
        cfg_ch.data      <= h[CFG_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.frame_h = h;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.expected_writes.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic pixel_beat_t make_pixel(int px, int py, longint x0, longint y0,
                                               longint x1, longint y1, longint x2,
                                               longint y2, longint z0, longint z1,
                                               longint z2, int color);
        pixel_beat_t b;
        b.pixel_x = px[7:0];
        b.pixel_y = py[7:0];
        b.vx = '{16'(x0), 16'(x1), 16'(x2)};
        b.vy = '{16'(y0), 16'(y1), 16'(y2)};
        b.vz = '{24'(z0), 24'(z1), 24'(z2)};
        b.tri_color = color[23:0];
        return b;
    endfunction

    // triangle well around the pixel, counter-clockwise
    function automatic pixel_beat_t cover_pixel(int px, int py, longint z, int color);
        longint cx, cy;
        cx = 16 * px;
        cy = 16 * py;
        return make_pixel(px, py, cx - 800, cy - 800, cx + 2400, cy - 800, cx - 800,
                          cy + 2400, z, z, z, color);
    endfunction

    function automatic pixel_beat_t random_pixel(int w, int h);
        pixel_beat_t b;
        int kind, span, lim_x, lim_y;
        longint cx, cy;
        kind = $urandom_range(99);
        lim_x = (w > 15 || w == 0) ? 16 : w + 1;
        lim_y = (h > 15 || h == 0) ? 16 : h + 1;
        if ($urandom_range(99) < 15) begin
            lim_x = 255;
            lim_y = 255;
        end
        b.pixel_x = 8'($urandom_range(lim_x, 0));
        b.pixel_y = 8'($urandom_range(lim_y, 0));
        cx = 16 * longint'(b.pixel_x);
        cy = 16 * longint'(b.pixel_y);
        span = kind < 55 ? 48 : kind < 75 ? 2400 : 16;
        for (int k = 0; k < 3; k++) begin
            b.vx[k] = 16'(cx + longint'($urandom_range(2 * span, 0)) - span);
            b.vy[k] = 16'(cy + longint'($urandom_range(2 * span, 0)) - span);
            if ($urandom_range(9) == 0) b.vz[k] = 24'($urandom());
            else b.vz[k] = 24'(longint'($urandom_range(4096, 0)) - 2048);
        end
        b.tri_color = 24'($urandom());
        if (kind >= 85 && kind < 90) begin
            b.vx[2] = b.vx[$urandom_range(1)];
            b.vy[2] = b.vy[0];
            if (kind[0]) b.vy[2] = b.vy[1];
        end else if (kind >= 90) begin
            b.pixel_x = 8'($urandom());
            b.pixel_y = 8'($urandom());
            for (int k = 0; k < 3; k++) begin
                b.vx[k] = 16'($urandom());
                b.vy[k] = 16'($urandom());
                b.vz[k] = 24'($urandom());
            end
        end
        return b;
    endfunction

    initial begin
        int frame_list[8][2];
        int per_phase;
        frame_list = '{'{256, 256}, '{16, 12}, '{1, 256}, '{256, 1},
                       '{511, 300}, '{0, 5}, '{7, 0}, '{3, 9}};
        per_phase = 190;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.pixel_x = '0;
        in_ch.pixel_y = '0;
        in_ch.vertex_x0 = '0;
        in_ch.vertex_y0 = '0;
        in_ch.vertex_z0 = '0;
        in_ch.vertex_x1 = '0;
        in_ch.vertex_y1 = '0;
        in_ch.vertex_z1 = '0;
        in_ch.vertex_x2 = '0;
        in_ch.vertex_y2 = '0;
        in_ch.vertex_z2 = '0;
        in_ch.tri_color = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = REG_FRAME_WIDTH;
        cfg_ch.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_pixel(cover_pixel(0, 0, 0, 24'hFFFFFF));
        send_pixel(cover_pixel(0, 0, 0, 24'h123456));
        send_pixel(cover_pixel(0, 0, -5, 24'h000000));
        send_pixel(cover_pixel(255, 255, FAR_DEPTH, 24'hFFFFFF));
        send_pixel(cover_pixel(255, 255, NEAR_DEPTH, 24'h80FF01));
        send_pixel(cover_pixel(255, 0, 1000, 24'hA5A5A5));
        send_pixel(cover_pixel(0, 255, -1000, 24'h5A5A5A));
        send_pixel(make_pixel(3, 3, 10, 10, 10, 10, 900, 40, 1, 2, 3, 24'hFFFFFF));
        send_pixel(make_pixel(3, 3, 0, 0, 900, 0, 1800, 0, 1, 2, 3, 24'hFFFFFF));
        send_pixel(make_pixel(4, 4, -32768, -32768, 32767, -32768, -32768, 32767,
                              FAR_DEPTH, NEAR_DEPTH, FAR_DEPTH, 24'hFFFFFF));
        send_pixel(make_pixel(5, 5, -32768, -32768, -32768, 32767, 32767, -32768,
                              NEAR_DEPTH, FAR_DEPTH, NEAR_DEPTH, 24'hFF00FF));
        send_pixel(make_pixel(6, 6, 96, 96, 96, 400, 400, 96, 100, 100, 100, 24'h00FF00));
        send_pixel(make_pixel(7, 7, 120, 0, 120, 400, 400, 0, 50, 60, 70, 24'hFFFFFF));
        send_pixel(make_pixel(8, 8, 136, 136, 300, 136, 136, 300, 9, 9, 9, 24'hFFFFFF));
        send_pixel(make_pixel(9, 9, 2000, 2000, 2100, 2000, 2000, 2100, 0, 0, 0,
                              24'hFFFFFF));
        send_pixel(make_pixel(10, 10, 0, 0, 4000, 8, 0, 4000, FAR_DEPTH, FAR_DEPTH,
                              NEAR_DEPTH, 24'h010101));
        send_pixel(make_pixel(11, 11, 32767, 32767, 32766, 32767, 32767, 32766,
                              -1, -1, -1, 24'hFFFFFF));
        drain();

        for (int p = 0; p < 8; p++) begin
            set_frame(frame_list[p][0], frame_list[p][1]);
            send_idle_pct  = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 16 : 0;
            recv_stall_pct = (p % 4 == 2) ? 71 : (p % 4 == 3) ? 16 : 0;
            for (int n = 0; n < per_phase; n++)
                send_pixel(random_pixel(frame_list[p][0], frame_list[p][1]));
            drain();
        end
        set_frame(256, 256);

        if (board.mismatches == 0 && board.expected_writes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
